[rtl/ncm_pkg.sv]
// ----------------------------------------------------------------------------
// ncm_pkg
// Types and fixed-point constants of the normalization cube map texel unit.
// ----------------------------------------------------------------------------
package ncm_pkg;

  localparam int unsigned FaceW         = 3;
  localparam int unsigned CoordW        = 10;
  localparam int unsigned CfgW          = 11;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned FaceSizeReset = 64;

  // coordinate divide: quotient of 2*idx*2^16 / (size-1), at most 2^17
  localparam int unsigned QCoordW    = 18;
  localparam int unsigned CoordSteps = 17;
  localparam logic [QCoordW-1:0] QCoordMax = 18'h20000;

  // direction components, signed Q2.16
  localparam int unsigned VecW = 18;
  localparam logic signed [VecW-1:0] OneQ16 = 18'sd65536;

  // squares unsigned Q1.32, their sum unsigned Q2.32
  localparam int unsigned SqW  = 33;
  localparam int unsigned SumW = 34;
  localparam logic [SumW-1:0] OneQ32 = 34'h1_0000_0000;

  // floor(2^64 / s)
  localparam int unsigned RemW       = 35;
  localparam int unsigned RecipW     = 33;
  localparam int unsigned RecipSteps = 32;

  // integer square root of the reciprocal, result unsigned Q1.16
  localparam int unsigned RootW     = 34;
  localparam int unsigned RootSteps = 17;
  localparam int unsigned RsqW      = 17;

  // scaled components and biased value
  localparam int unsigned ProdW  = 36;
  localparam int unsigned ClampW = 34;
  localparam logic [ClampW-1:0] OneQ33 = 34'h2_0000_0000;

  typedef enum logic [FaceW-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_e;

  typedef struct packed {
    logic [FaceW-1:0]  face;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
  } texel_req_t;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } texel_rgb_t;

endpackage

[rtl/normalization_cube_map_texel_top.sv]
// ----------------------------------------------------------------------------
// normalization_cube_map_texel_top
// Returns the RGB bytes of the unit normal through one cube map texel. Takes
// one texel beat per clock and returns one result beat per clock while no
// result waits under stall; a beat passes 38 register stages, the last of
// them the output register. The stage count is set by the digit recurrences:
// the coordinate divide (3 quotient bits a stage), the 2^64/s reciprocal
// divide (2 bits a stage) and the integer square root (2 root bits a stage).
// The whole pipeline holds while a result waits under stall, and empty stages
// fill while it does not. face_size is written through the config channel,
// which is always ready; write it only while no beat is in flight. Faces 6
// and 7 return black.
// ----------------------------------------------------------------------------
module normalization_cube_map_texel_top #(
  parameter int unsigned MAX_FACE_SIZE = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ncm_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ncm_pkg::texel_req_t       in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ncm_pkg::texel_rgb_t       out_data_o
);

  localparam int unsigned DivW   = $clog2(MAX_FACE_SIZE);
  localparam int unsigned RemCW  = DivW + 1;
  localparam int unsigned LimW   = ($clog2(MAX_FACE_SIZE + 1) > ncm_pkg::CfgW) ?
                                   $clog2(MAX_FACE_SIZE + 1) : ncm_pkg::CfgW;
  localparam int unsigned XW     = (DivW > ncm_pkg::CoordW) ? DivW : ncm_pkg::CoordW;
  localparam int unsigned ResetDiv = ((ncm_pkg::FaceSizeReset > MAX_FACE_SIZE) ?
                                      MAX_FACE_SIZE : ncm_pkg::FaceSizeReset) - 1;

  localparam int unsigned QCW      = ncm_pkg::QCoordW;
  localparam int unsigned VecW     = ncm_pkg::VecW;
  localparam int unsigned SqW      = ncm_pkg::SqW;
  localparam int unsigned SumW     = ncm_pkg::SumW;
  localparam int unsigned RemW     = ncm_pkg::RemW;
  localparam int unsigned RecipW   = ncm_pkg::RecipW;
  localparam int unsigned RootW    = ncm_pkg::RootW;
  localparam int unsigned RsqW     = ncm_pkg::RsqW;
  localparam int unsigned ProdW    = ncm_pkg::ProdW;
  localparam int unsigned ClampW   = ncm_pkg::ClampW;

  localparam int unsigned CoordPer = 3;
  localparam int unsigned CoordStg = (ncm_pkg::CoordSteps + CoordPer - 1) / CoordPer;
  localparam int unsigned RecipPer = 2;
  localparam int unsigned RecipStg = (ncm_pkg::RecipSteps + RecipPer - 1) / RecipPer;
  localparam int unsigned RootPer  = 2;
  localparam int unsigned RootStg  = (ncm_pkg::RootSteps + RootPer - 1) / RootPer;

  localparam int unsigned VecStg  = CoordStg + 1;
  localparam int unsigned SqStg   = VecStg + 1;
  localparam int unsigned SumStg  = SqStg + 1;
  localparam int unsigned RootEnd = SumStg + RecipStg + RootStg;
  localparam int unsigned NStg    = RootEnd + 4;

  typedef struct packed {
    logic [ncm_pkg::FaceW-1:0] face;
    logic [QCW-1:0]            qw;
    logic [QCW-1:0]            qh;
    logic [RemCW-1:0]          rw;
    logic [RemCW-1:0]          rh;
  } crd_t;

  typedef struct packed {
    logic                   bad;
    logic signed [VecW-1:0] a0;
    logic signed [VecW-1:0] a1;
    logic signed [VecW-1:0] a2;
  } vec_t;

  typedef struct packed {
    vec_t           v;
    logic [SqW-1:0] s0;
    logic [SqW-1:0] s1;
    logic [SqW-1:0] s2;
  } sq_t;

  typedef struct packed {
    vec_t              v;
    logic [SumW-1:0]   s;
    logic [RemW-1:0]   rem;
    logic [RecipW-1:0] q;
  } rd_t;

  typedef struct packed {
    vec_t              v;
    logic [RecipW-1:0] val;
    logic [RootW-1:0]  res;
  } rt_t;

  typedef struct packed {
    logic                    bad;
    logic signed [ProdW-1:0] n0;
    logic signed [ProdW-1:0] n1;
    logic signed [ProdW-1:0] n2;
  } mul_t;

  typedef struct packed {
    logic              bad;
    logic [ClampW-1:0] t0;
    logic [ClampW-1:0] t1;
    logic [ClampW-1:0] t2;
  } cl_t;

  function automatic logic [SqW-1:0] square(input logic signed [VecW-1:0] a);
    logic signed [2*VecW-1:0] p;
    p = a * a;
    return p[SqW-1:0];
  endfunction

  function automatic logic signed [ProdW-1:0] scale(input logic signed [VecW-1:0] a,
                                                    input logic [RsqW-1:0] r);
    logic signed [ProdW-1:0] p;
    p = a * signed'({1'b0, r});
    return p;
  endfunction

  function automatic logic [ClampW-1:0] bias(input logic signed [ProdW-1:0] n);
    logic signed [ProdW:0] u;
    u = (ProdW + 1)'(n) + signed'((ProdW + 1)'(ncm_pkg::OneQ32));
    if (u < 0) begin
      return '0;
    end else if (u > signed'((ProdW + 1)'(ncm_pkg::OneQ33))) begin
      return ncm_pkg::OneQ33;
    end
    return u[ClampW-1:0];
  endfunction

  function automatic logic [ncm_pkg::ByteW-1:0] to_byte(input logic [ClampW-1:0] t);
    logic [ClampW+7:0] p;
    p = {t, 8'b0} - (ClampW + 8)'(t);
    return p[ClampW+6:ClampW-1];
  endfunction

  // config: divisor size-1 with the size clamped to 2..MAX_FACE_SIZE
  logic [DivW-1:0] fdiv_q, fdiv_d;
  logic [LimW-1:0] fs_eff;

  always_comb begin
    fs_eff = LimW'(cfg_data_i);
    if (fs_eff < LimW'(2)) begin
      fs_eff = LimW'(2);
    end else if (fs_eff > LimW'(MAX_FACE_SIZE)) begin
      fs_eff = LimW'(MAX_FACE_SIZE);
    end
    fdiv_d = DivW'(fs_eff - LimW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdiv_q <= DivW'(ResetDiv);
    end else if (cfg_valid_i && cfg_ready_o) begin
      fdiv_q <= fdiv_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // pipeline control
  logic [NStg-1:0] vld_q;
  logic            pipe_adv;

  assign pipe_adv    = !vld_q[NStg-1] || !out_stall_i;
  assign in_stall_o  = !pipe_adv;
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // stage 0: clamp coordinates, integer quotient bit
  crd_t            cd_q [0:CoordStg];
  crd_t            cd0_d;
  logic [DivW-1:0] col_c, row_c;

  always_comb begin
    col_c = (XW'(in_data_i.column) > XW'(fdiv_q)) ? fdiv_q : DivW'(in_data_i.column);
    row_c = (XW'(in_data_i.row) > XW'(fdiv_q)) ? fdiv_q : DivW'(in_data_i.row);
    cd0_d.face = in_data_i.face;
    cd0_d.qw   = QCW'(col_c == fdiv_q);
    cd0_d.qh   = QCW'(row_c == fdiv_q);
    cd0_d.rw   = (col_c == fdiv_q) ? '0 : RemCW'(col_c);
    cd0_d.rh   = (row_c == fdiv_q) ? '0 : RemCW'(row_c);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      cd_q[0] <= cd0_d;
    end
  end

  // coordinate divide, fraction bits
  for (genvar g = 1; g <= CoordStg; g++) begin : g_crd
    crd_t nx;
    always_comb begin
      logic [RemCW-1:0] xw;
      logic [RemCW-1:0] xh;
      nx = cd_q[g-1];
      for (int j = 0; j < CoordPer; j++) begin
        if ((g - 1) * CoordPer + j < ncm_pkg::CoordSteps) begin
          xw = {nx.rw[RemCW-2:0], 1'b0};
          xh = {nx.rh[RemCW-2:0], 1'b0};
          if (xw >= RemCW'(fdiv_q)) begin
            nx.rw = xw - RemCW'(fdiv_q);
            nx.qw = {nx.qw[QCW-2:0], 1'b1};
          end else begin
            nx.rw = xw;
            nx.qw = {nx.qw[QCW-2:0], 1'b0};
          end
          if (xh >= RemCW'(fdiv_q)) begin
            nx.rh = xh - RemCW'(fdiv_q);
            nx.qh = {nx.qh[QCW-2:0], 1'b1};
          end else begin
            nx.rh = xh;
            nx.qh = {nx.qh[QCW-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        cd_q[g] <= nx;
      end
    end
  end

  // face select
  vec_t                   vec_q, vec_d;
  logic signed [VecW-1:0] cw, ch;

  always_comb begin
    cw = signed'(cd_q[CoordStg].qw - QCW'(ncm_pkg::OneQ16));
    ch = signed'(cd_q[CoordStg].qh - QCW'(ncm_pkg::OneQ16));
    vec_d.bad = 1'b0;
    case (cd_q[CoordStg].face)
      ncm_pkg::FACE_POS_X: begin
        vec_d.a0 = ncm_pkg::OneQ16;
        vec_d.a1 = -ch;
        vec_d.a2 = -cw;
      end
      ncm_pkg::FACE_NEG_X: begin
        vec_d.a0 = -ncm_pkg::OneQ16;
        vec_d.a1 = -ch;
        vec_d.a2 = cw;
      end
      ncm_pkg::FACE_POS_Y: begin
        vec_d.a0 = cw;
        vec_d.a1 = ncm_pkg::OneQ16;
        vec_d.a2 = ch;
      end
      ncm_pkg::FACE_NEG_Y: begin
        vec_d.a0 = cw;
        vec_d.a1 = -ncm_pkg::OneQ16;
        vec_d.a2 = -ch;
      end
      ncm_pkg::FACE_POS_Z: begin
        vec_d.a0 = cw;
        vec_d.a1 = -ch;
        vec_d.a2 = ncm_pkg::OneQ16;
      end
      ncm_pkg::FACE_NEG_Z: begin
        vec_d.a0 = -cw;
        vec_d.a1 = -ch;
        vec_d.a2 = -ncm_pkg::OneQ16;
      end
      default: begin
        vec_d.bad = 1'b1;
        vec_d.a0  = ncm_pkg::OneQ16;
        vec_d.a1  = '0;
        vec_d.a2  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      vec_q <= vec_d;
    end
  end

  // squares
  sq_t sq_q, sq_d;

  always_comb begin
    sq_d.v  = vec_q;
    sq_d.s0 = square(vec_q.a0);
    sq_d.s1 = square(vec_q.a1);
    sq_d.s2 = square(vec_q.a2);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      sq_q <= sq_d;
    end
  end

  // sum and leading reciprocal bit
  rd_t             rd_q [0:RecipStg];
  rd_t             rd0_d;
  logic [SumW-1:0] sum;

  always_comb begin
    sum       = SumW'(sq_q.s0) + SumW'(sq_q.s1) + SumW'(sq_q.s2);
    rd0_d.v   = sq_q.v;
    rd0_d.s   = sum;
    rd0_d.q   = RecipW'(sum == ncm_pkg::OneQ32);
    rd0_d.rem = (sum == ncm_pkg::OneQ32) ? '0 : RemW'(ncm_pkg::OneQ32);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      rd_q[0] <= rd0_d;
    end
  end

  // reciprocal divide 2^64 / s
  for (genvar g = 1; g <= RecipStg; g++) begin : g_rd
    rd_t nx;
    always_comb begin
      logic [RemW-1:0] x;
      nx = rd_q[g-1];
      for (int j = 0; j < RecipPer; j++) begin
        if ((g - 1) * RecipPer + j < ncm_pkg::RecipSteps) begin
          x = {nx.rem[RemW-2:0], 1'b0};
          if (x >= RemW'(nx.s)) begin
            nx.rem = x - RemW'(nx.s);
            nx.q   = {nx.q[RecipW-2:0], 1'b1};
          end else begin
            nx.rem = x;
            nx.q   = {nx.q[RecipW-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        rd_q[g] <= nx;
      end
    end
  end

  // integer square root of the reciprocal
  rt_t rt_q  [1:RootStg];
  rt_t rt_in [1:RootStg];

  for (genvar g = 1; g <= RootStg; g++) begin : g_rt
    rt_t nx;
    if (g == 1) begin : g_src
      assign rt_in[g] = {rd_q[RecipStg].v, rd_q[RecipStg].q, RootW'(0)};
    end else begin : g_src
      assign rt_in[g] = rt_q[g-1];
    end
    always_comb begin
      logic [RootW-1:0] bitv;
      logic [RootW-1:0] trial;
      nx = rt_in[g];
      for (int j = 0; j < RootPer; j++) begin
        if ((g - 1) * RootPer + j < ncm_pkg::RootSteps) begin
          bitv  = RootW'(1) << (2 * (ncm_pkg::RootSteps - 1 - ((g - 1) * RootPer + j)));
          trial = nx.res + bitv;
          if (RootW'(nx.val) >= trial) begin
            nx.val = RecipW'(RootW'(nx.val) - trial);
            nx.res = (nx.res >> 1) + bitv;
          end else begin
            nx.res = nx.res >> 1;
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        rt_q[g] <= nx;
      end
    end
  end

  // scale components by the reciprocal root
  mul_t            mul_q, mul_d;
  logic [RsqW-1:0] rsq;

  always_comb begin
    rsq       = rt_q[RootStg].res[RsqW-1:0];
    mul_d.bad = rt_q[RootStg].v.bad;
    mul_d.n0  = scale(rt_q[RootStg].v.a0, rsq);
    mul_d.n1  = scale(rt_q[RootStg].v.a1, rsq);
    mul_d.n2  = scale(rt_q[RootStg].v.a2, rsq);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      mul_q <= mul_d;
    end
  end

  // bias and saturate
  cl_t cl_q, cl_d;

  always_comb begin
    cl_d.bad = mul_q.bad;
    cl_d.t0  = bias(mul_q.n0);
    cl_d.t1  = bias(mul_q.n1);
    cl_d.t2  = bias(mul_q.n2);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      cl_q <= cl_d;
    end
  end

  // byte scale and output register
  ncm_pkg::texel_rgb_t out_q, out_d;

  always_comb begin
    out_d.red   = cl_q.bad ? '0 : to_byte(cl_q.t0);
    out_d.green = cl_q.bad ? '0 : to_byte(cl_q.t1);
    out_d.blue  = cl_q.bad ? '0 : to_byte(cl_q.t2);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_coord_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[CoordStg] |-> cd_q[CoordStg].qw <= ncm_pkg::QCoordMax)
    else $error("coordinate quotient above 2.0");

  a_unit_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[VecStg] && !vec_q.bad |->
      vec_q.a0 == ncm_pkg::OneQ16 || vec_q.a0 == -ncm_pkg::OneQ16 ||
      vec_q.a1 == ncm_pkg::OneQ16 || vec_q.a1 == -ncm_pkg::OneQ16 ||
      vec_q.a2 == ncm_pkg::OneQ16 || vec_q.a2 == -ncm_pkg::OneQ16)
    else $error("direction has no unit major axis");

  a_sum_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SumStg] && !rd_q[0].v.bad |-> rd_q[0].s >= ncm_pkg::OneQ32)
    else $error("squared length below 1.0");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[RootEnd] && !rt_q[RootStg].v.bad |->
      rt_q[RootStg].res <= RootW'(unsigned'(ncm_pkg::OneQ16)) &&
      rt_q[RootStg].res >= RootW'(unsigned'(ncm_pkg::OneQ16)) >> 1)
    else $error("reciprocal root out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_adv |=> $stable(vld_q))
    else $error("pipeline moved while held");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the normalization cube map texel unit. Requests go in through
// a stalled stream with random bursts and gaps, and results come back under a
// random stall pattern. A local fixed-point predictor works out the RGB bytes
// of every accepted request. The checker compares each result beat with the
// oldest prediction, field by field. The face size is reprogrammed between
// phases while the pipeline is empty, and takes in-range, out-of-range and
// non-power-of-two values.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MAX_FACE       = 1024;
  localparam longint      ONE_Q16        = 65536;
  localparam int unsigned PIPE_LATENCY   = 38;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [ncm_pkg::FaceW-1:0] FACE_UNDEF_6 = 3'd6;
  localparam logic [ncm_pkg::FaceW-1:0] FACE_UNDEF_7 = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid;
  logic                     cfg_ready_o;
  logic [ncm_pkg::CfgW-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_stall_o;
  ncm_pkg::texel_req_t      in_data;
  logic                     out_valid_o;
  logic                     out_stall = 1'b0;
  ncm_pkg::texel_rgb_t      out_data_o;

  ncm_pkg::texel_rgb_t rgb_pending[$];
  ncm_pkg::texel_rgb_t want_rgb;
  int unsigned face_size_cur = ncm_pkg::FaceSizeReset;
  int unsigned fails = 0;
  int unsigned quiet_cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_seg = 0;

  normalization_cube_map_texel_top #(
    .MAX_FACE_SIZE(MAX_FACE)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_size(int unsigned s);
    if (s < 2) return 2;
    if (s > MAX_FACE) return MAX_FACE;
    return s;
  endfunction

  function automatic longint coord_q16(longint unsigned idx, longint unsigned size);
    if (idx >= size) idx = size - 1;
    return longint'((idx * 2 * ONE_Q16) / (size - 1)) - ONE_Q16;
  endfunction

  function automatic ncm_pkg::texel_rgb_t normal_rgb(ncm_pkg::texel_req_t req,
                                                      int unsigned size_reg);
    longint unsigned size;
    longint          w;
    longint          h;
    longint          vec[3];
    longint unsigned sum;
    logic [127:0]    recip;
    longint unsigned root;
    longint unsigned cand;
    longint          biased;
    longint unsigned bytes[3];
    size = clamp_size(size_reg);
    w = coord_q16(req.column, size);
    h = coord_q16(req.row, size);
    case (req.face)
      ncm_pkg::FACE_POS_X: vec = '{ONE_Q16, -h, -w};
      ncm_pkg::FACE_NEG_X: vec = '{-ONE_Q16, -h, w};
      ncm_pkg::FACE_POS_Y: vec = '{w, ONE_Q16, h};
      ncm_pkg::FACE_NEG_Y: vec = '{w, -ONE_Q16, -h};
      ncm_pkg::FACE_POS_Z: vec = '{w, -h, ONE_Q16};
      ncm_pkg::FACE_NEG_Z: vec = '{-w, -h, -ONE_Q16};
      default:             return '0;
    endcase
    sum = vec[0] * vec[0] + vec[1] * vec[1] + vec[2] * vec[2];
    recip = (128'd1 << 64) / sum;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= recip) root = cand;
    end
    for (int k = 0; k < 3; k++) begin
      biased = 64'sd4294967296 + vec[k] * longint'(root);
      if (biased < 0) biased = 0;
      if (biased > 64'sd8589934592) biased = 64'sd8589934592;
      bytes[k] = (longint'(biased) * 255) >>> 33;
      if (bytes[k] > 255) bytes[k] = 255;
    end
    return '{red: bytes[0][7:0], green: bytes[1][7:0], blue: bytes[2][7:0]};
  endfunction

  function automatic ncm_pkg::texel_req_t rand_texel();
    ncm_pkg::texel_req_t req;
    int unsigned         eff;
    int unsigned         pick;
    eff = clamp_size(face_size_cur);
    pick = $urandom_range(0, 99);
    req.face = 3'($urandom_range(ncm_pkg::FACE_POS_X, ncm_pkg::FACE_NEG_Z));
    req.column = 10'($urandom_range(0, eff - 1));
    req.row = 10'($urandom_range(0, eff - 1));
    if (pick >= 80) begin
      req.column = 10'($urandom_range(0, 1023));
      req.row = 10'($urandom_range(0, 1023));
    end
    if (pick >= 92) req.face = 3'($urandom_range(FACE_UNDEF_6, FACE_UNDEF_7));
    return req;
  endfunction

  // one beat; returns in the time step of the accepting edge
  task automatic send_texel(ncm_pkg::texel_req_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rgb_pending = {rgb_pending, normal_rgb(req, face_size_cur)};
  endtask

  task automatic pause_sender(int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (rgb_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_face_size(int unsigned value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value[ncm_pkg::CfgW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    face_size_cur = value & 11'h7FF;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_stream(int unsigned count);
    int unsigned burst;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 48);
      for (int unsigned k = 0; k < burst && sent < count; k++) begin
        send_texel(rand_texel());
        sent++;
      end
      if ($urandom_range(0, 3) != 0)
        pause_sender($urandom_range(0, 9) == 0 ? $urandom_range(13, 45)
                                                : $urandom_range(1, 12));
    end
  endtask

  task automatic test_face_corners();
    ncm_pkg::texel_req_t req;
    for (int f = ncm_pkg::FACE_POS_X; f <= ncm_pkg::FACE_NEG_Z; f++) begin
      req = '{face: 3'(f), column: 10'd0, row: 10'd0};
      send_texel(req);
      req = '{face: 3'(f), column: 10'd63, row: 10'd63};
      send_texel(req);
    end
    send_texel('{face: ncm_pkg::FACE_POS_Z, column: 10'd31, row: 10'd32});
    send_texel('{face: ncm_pkg::FACE_NEG_Z, column: 10'd32, row: 10'd31});
    // past the last texel
    send_texel('{face: ncm_pkg::FACE_POS_X, column: 10'd1023, row: 10'd1023});
    send_texel('{face: ncm_pkg::FACE_NEG_Y, column: 10'd64, row: 10'd0});
    // undefined faces
    send_texel('{face: FACE_UNDEF_6, column: 10'd1023, row: 10'd1023});
    send_texel('{face: FACE_UNDEF_7, column: 10'd0, row: 10'd0});
    wait_drained();
  endtask

  task automatic test_size_extremes();
    int unsigned sizes[7] = '{2, 1024, 0, 1, 2047, 1025, 4};
    foreach (sizes[i]) begin
      write_face_size(sizes[i]);
      send_stream(30);
    end
  endtask

  task automatic test_non_pow2();
    int unsigned sizes[4] = '{3, 1000, 100, 513};
    foreach (sizes[i]) begin
      write_face_size(sizes[i]);
      send_stream(30);
    end
  endtask

  task automatic test_drain_pause();
    write_face_size(ncm_pkg::FaceSizeReset);
    for (int k = 0; k < 20; k++) send_texel(rand_texel());
    wait_drained();
    for (int k = 0; k < 20; k++) send_texel(rand_texel());
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      if ($urandom_range(0, 3) == 0) write_face_size($urandom_range(0, 2047));
      else write_face_size(1 << $urandom_range(1, 10));
      send_stream(185);
    end
  endtask

  initial begin
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_face_corners();
    test_size_extremes();
    test_non_pow2();
    test_drain_pause();
    test_random();
    wait_drained();
    repeat (PIPE_LATENCY + 12) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_mode <= STALL_NONE;
      stall_seg  <= 0;
    end else begin
      if (stall_seg == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        stall_seg  <= $urandom_range(20, 300);
      end else begin
        stall_seg <= stall_seg - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
        STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
        default:     out_stall <= ($urandom_range(0, 15) < 13);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (rgb_pending.size() == 0) begin
        $display("%0t: result beat, expected none, got %h", $time, out_data_o);
        fails++;
      end else begin
        want_rgb = rgb_pending.pop_front();
        if (out_data_o.red !== want_rgb.red || out_data_o.green !== want_rgb.green ||
            out_data_o.blue !== want_rgb.blue) begin
          $display("%0t: rgb mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   $time, want_rgb.red, want_rgb.green, want_rgb.blue,
                   out_data_o.red, out_data_o.green, out_data_o.blue);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
rtl/ncm_pkg.sv
rtl/normalization_cube_map_texel_top.sv
verif/tb_top.sv
